### design/bss_pkg.sv
// ----------------------------------------------------------------------------
// Byte signature scanner package
// Shared constants, item kind codes and the control struct of the scanner.
// ----------------------------------------------------------------------------
package bss_pkg;

  // Default depth of the signature store.
  localparam int PATTERN_MAX_DEFAULT = 256;

  // Fixed field widths.
  localparam int BYTE_W   = 8;
  localparam int LENGTH_W = 9;
  localparam int OFFSET_W = 48;
  localparam int COUNT_W  = 32;

  // Saturation limits.
  localparam logic [OFFSET_W-1:0] OFFSET_MAX = {OFFSET_W{1'b1}};
  localparam logic [COUNT_W-1:0]  COUNT_MAX  = {COUNT_W{1'b1}};

  // Item kinds.
  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_SCAN    = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  // One-cycle operation strobes handed to the matcher.
  typedef struct packed {
    logic load;
    logic scan;
    logic restart;
  } op_t;

endpackage

### design/bss_matcher.sv
// ----------------------------------------------------------------------------
// Byte signature matcher
// Holds the signature bytes and the partial prefix match bits, advances the
// bits by one data byte per scan beat and flags a complete occurrence.
// ----------------------------------------------------------------------------
module bss_matcher #(
  parameter int PATTERN_MAX = bss_pkg::PATTERN_MAX_DEFAULT,
  localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  bss_pkg::op_t             op,
  input  logic [bss_pkg::BYTE_W-1:0] load_index,
  input  logic [bss_pkg::BYTE_W-1:0] data_byte,
  input  logic [IDX_W-1:0]         len_m1,
  output logic                     hit
);
  import bss_pkg::*;

  logic [BYTE_W-1:0]      store [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] prefix_bits;
  logic [PATTERN_MAX-1:0] prefix_next;
  logic [PATTERN_MAX-1:0] byte_eq;
  logic [IDX_W-1:0]       load_addr;
  logic                   load_in_range;

  // Loads beyond the store depth are dropped.
  assign load_addr     = IDX_W'(load_index);
  assign load_in_range = {{(32-BYTE_W){1'b0}}, load_index} < 32'(PATTERN_MAX);

  // Signature store: one byte per entry, written by index.
  always_ff @(posedge clk) begin
    if (op.load && load_in_range) begin
      store[load_addr] <= data_byte;
    end
  end

  // Each entry is compared with the data byte at its own place.
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_entry
    assign byte_eq[k] = (store[k] == data_byte);
  end

  // Every partial match grows by one byte or dies.
  assign prefix_next[0] = byte_eq[0];
  for (genvar k = 1; k < PATTERN_MAX; k++) begin : g_prefix
    assign prefix_next[k] = prefix_bits[k-1] & byte_eq[k];
  end

  always_ff @(posedge clk) begin
    if (rst || op.restart) begin
      prefix_bits <= '0;
    end else if (op.scan) begin
      prefix_bits <= prefix_next;
    end
  end

  // A full-length prefix match ends an occurrence.
  assign hit = prefix_next[len_m1];

endmodule

### design/byte_signature_scanner_top.sv
// ----------------------------------------------------------------------------
// Byte signature scanner
// Reports every occurrence, overlapping ones included, of a loaded byte
// signature in a byte stream.
// ----------------------------------------------------------------------------
// Input beats (in_valid/in_ready) carry kind, pattern_index and byte_value:
// a load writes one signature byte, a scan pushes one stream byte and a
// restart clears the match history, the offset and the match count. Kind 3
// is dropped. Result beats (out_valid/out_ready) carry match_offset, the
// offset of the first byte of the occurrence, and match_number, the running
// count since restart; both saturate. Only a scan beat that completes an
// occurrence gives a result.
// The signature length is written through cfg_wr_en/cfg_wr_data; the user
// must write it only while the block is idle, which the block does not
// enforce. Zero acts as one and values above the store depth are clipped.
// One beat is taken per clock while no stalled result holds the input
// register. A beat is held in the input register and then its result is
// registered in the result register, from which the receiver takes it.
// The input register advances whenever the result register is empty or
// being emptied, so a stalled receiver holds one result and one input beat.
// Reset (rst, synchronous) clears the history, the counters and both
// registers and sets the length to one; the signature bytes are undefined
// until loaded.
// ----------------------------------------------------------------------------
module byte_signature_scanner_top #(
  parameter int PATTERN_MAX = bss_pkg::PATTERN_MAX_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [bss_pkg::LENGTH_W-1:0] cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   kind,
  input  logic [bss_pkg::BYTE_W-1:0]   pattern_index,
  input  logic [bss_pkg::BYTE_W-1:0]   byte_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bss_pkg::OFFSET_W-1:0] match_offset,
  output logic [bss_pkg::COUNT_W-1:0]  match_number
);
  import bss_pkg::*;

  localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int EW    = (IDX_W + 1 > LENGTH_W) ? IDX_W + 1 : LENGTH_W;

  logic [LENGTH_W-1:0] pattern_length;
  logic                s1_valid;
  logic [1:0]          s1_kind;
  logic [BYTE_W-1:0]   s1_index;
  logic [BYTE_W-1:0]   s1_byte;
  logic                s1_advance;
  op_t                 op;
  logic                hit;
  logic [EW-1:0]       len_raw;
  logic [EW-1:0]       len_eff;
  logic [EW-1:0]       len_m1_wide;
  logic [OFFSET_W-1:0] len_m1_off;
  logic [OFFSET_W-1:0] stream_offset;
  logic [OFFSET_W-1:0] stream_offset_next;
  logic [OFFSET_W-1:0] start_offset;
  logic [COUNT_W-1:0]  matches_found;
  logic [COUNT_W-1:0]  matches_found_next;

  // Length register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= LENGTH_W'(1);
    end else if (cfg_wr_en) begin
      pattern_length <= cfg_wr_data;
    end
  end

  // Effective length, clipped to the range one to the store depth.
  always_comb begin
    len_raw = EW'(pattern_length);
    if (len_raw == '0) begin
      len_eff = EW'(1);
    end else if (len_raw > EW'(PATTERN_MAX)) begin
      len_eff = EW'(PATTERN_MAX);
    end else begin
      len_eff = len_raw;
    end
    len_m1_wide = len_eff - EW'(1);
  end
  assign len_m1_off = OFFSET_W'(len_m1_wide);

  // Input register; it moves on whenever the result register can take a beat.
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind  <= kind;
      s1_index <= pattern_index;
      s1_byte  <= byte_value;
    end
  end

  // Decode the beat in the input register.
  always_comb begin
    op = '0;
    if (s1_advance) begin
      case (s1_kind)
        KIND_LOAD:    op.load    = 1'b1;
        KIND_SCAN:    op.scan    = 1'b1;
        KIND_RESTART: op.restart = 1'b1;
        default:      op         = '0;
      endcase
    end
  end

  bss_matcher #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_matcher (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .load_index (s1_index),
    .data_byte  (s1_byte),
    .len_m1     (len_m1_wide[IDX_W-1:0]),
    .hit        (hit)
  );

  // Saturating offset and count, and the start of the occurrence.
  assign stream_offset_next = (stream_offset == OFFSET_MAX) ? stream_offset
                                                            : stream_offset + 1'b1;
  assign matches_found_next = (matches_found == COUNT_MAX) ? matches_found
                                                           : matches_found + 1'b1;
  assign start_offset = (stream_offset >= len_m1_off) ? stream_offset - len_m1_off
                                                      : '0;

  always_ff @(posedge clk) begin
    if (rst || op.restart) begin
      stream_offset <= '0;
      matches_found <= '0;
    end else if (op.scan) begin
      stream_offset <= stream_offset_next;
      if (hit) begin
        matches_found <= matches_found_next;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op.scan && hit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op.scan && hit) begin
      match_offset <= start_offset;
      match_number <= matches_found_next;
    end
  end

endmodule

### design/bss_checker.sv
// ----------------------------------------------------------------------------
// Byte signature scanner checker
// Port-level checks of the scanner's timing and flow control.
// ----------------------------------------------------------------------------
module bss_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [1:0]                   kind,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [bss_pkg::OFFSET_W-1:0] match_offset,
  input logic [bss_pkg::COUNT_W-1:0]  match_number
);
  import bss_pkg::*;

  // A held result beat keeps its payload.
  a_out_hold : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(match_offset) &&
                                $stable(match_number))
    else $error("result beat changed while stalled");

  // Reset empties both registers.
  a_reset_empty : assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not empty after reset");

  // Input is refused only behind a stalled result.
  a_ready_low : assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input refused without a stalled result");

  // A fresh result comes from a scan beat accepted into the input register.
  a_result_source : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && (kind == KIND_SCAN), 2))
    else $error("result without a matching scan beat");

endmodule

bind byte_signature_scanner_top bss_checker u_bss_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .kind         (kind),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .match_offset (match_offset),
  .match_number (match_number)
);
